// ----- design/utf8v_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package utf8v_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned CP_W    = 21;
	localparam int unsigned PEND_W  = 2;
	localparam int unsigned SEQW_W  = 3;

	localparam logic [LEN_W-1:0]   MAX_BYTES_RESET = 16'hffff;
	localparam logic [LEN_W-1:0]   UNIT_MAX        = 16'hffff;
	localparam logic [COUNT_W-1:0] BYTE_COUNT_MAX  = 17'h1ffff;

	// Result codes.
	typedef enum logic [1:0] {
		STATUS_VALID    = 2'd0,
		STATUS_TOO_LONG = 2'd1,
		STATUS_NUL      = 2'd2,
		STATUS_BAD_UTF8 = 2'd3
	} status_t;

	// Sequence widths held while a multi-byte sequence is open.
	localparam logic [SEQW_W-1:0] SEQ_NONE = 3'd0;
	localparam logic [SEQW_W-1:0] SEQ_TWO  = 3'd2;
	localparam logic [SEQW_W-1:0] SEQ_THREE = 3'd3;
	localparam logic [SEQW_W-1:0] SEQ_FOUR = 3'd4;

	typedef struct packed {
		logic [PEND_W-1:0]  pending;
		logic [SEQW_W-1:0]  seq_width;
		logic [CP_W-1:0]    cp_acc;
		logic [LEN_W-1:0]   units;
		logic [COUNT_W-1:0] byte_count;
		logic               nul_seen;
		logic               bad;
	} text_state_t;

	localparam text_state_t TEXT_STATE_CLEAR = '0;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] utf16_units;
	} result_t;

endpackage

`default_nettype wire

// ----- design/utf8v_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface utf8v_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       has_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output has_byte, output end_of_text,
		input ready);
	modport sink (input valid, input text_byte, input has_byte, input end_of_text,
		output ready);
endinterface

interface utf8v_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] utf16_units;

	modport source (output valid, output status, output utf16_units, input ready);
	modport sink (input valid, input status, input utf16_units, output ready);
endinterface

interface utf8v_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_text_bytes;

	modport source (output valid, output max_text_bytes, input ready);
	modport sink (input valid, input max_text_bytes, output ready);
endinterface

`default_nettype wire

// ----- design/utf8v_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8v_step
	import utf8v_pkg::*;
(
	input  wire text_state_t           cur,
	input  wire logic [BYTE_W-1:0]     text_byte,
	input  wire logic                  has_byte,
	input  wire logic                  end_of_text,
	input  wire logic [LEN_W-1:0]      max_text_bytes,
	output text_state_t                nxt,
	output result_t                    result
);

	text_state_t       st;
	logic [CP_W-1:0]   cp_ext;
	logic [1:0]        add_units;
	logic [LEN_W:0]    unit_sum;
	logic              too_long;

	always_comb begin
		st        = cur;
		add_units = 2'd0;
		cp_ext    = {cur.cp_acc[CP_W-7:0], text_byte[5:0]};

		if (has_byte) begin
			if (cur.byte_count != BYTE_COUNT_MAX) begin
				st.byte_count = cur.byte_count + COUNT_W'(1);
			end
			if (text_byte == '0) begin
				st.nul_seen = 1'b1;
			end
			if (!cur.bad) begin
				if (cur.pending == '0) begin
					if (text_byte[7] == 1'b0) begin
						add_units = 2'd1;
					end else if (text_byte >= 8'hc2 && text_byte <= 8'hdf) begin
						st.cp_acc    = CP_W'(text_byte[4:0]);
						st.seq_width = SEQ_TWO;
						st.pending   = 2'd1;
					end else if (text_byte >= 8'he0 && text_byte <= 8'hef) begin
						st.cp_acc    = CP_W'(text_byte[3:0]);
						st.seq_width = SEQ_THREE;
						st.pending   = 2'd2;
					end else if (text_byte >= 8'hf0 && text_byte <= 8'hf4) begin
						st.cp_acc    = CP_W'(text_byte[2:0]);
						st.seq_width = SEQ_FOUR;
						st.pending   = 2'd3;
					end else begin
						st.bad = 1'b1;
					end
				end else if (text_byte[7:6] != 2'b10) begin
					st.bad = 1'b1;
				end else begin
					st.cp_acc  = cp_ext;
					st.pending = cur.pending - PEND_W'(1);
					if (cur.pending == 2'd1) begin
						// sequence complete: reject overlong, surrogate, out of range
						if ((cur.seq_width == SEQ_TWO && cp_ext < 21'h80) ||
							(cur.seq_width == SEQ_THREE && cp_ext < 21'h800) ||
							(cur.seq_width == SEQ_FOUR && cp_ext < 21'h10000) ||
							(cp_ext >= 21'hd800 && cp_ext <= 21'hdfff) ||
							cp_ext > 21'h10ffff) begin
							st.bad = 1'b1;
						end else if (cp_ext > 21'hffff) begin
							add_units = 2'd2;
						end else begin
							add_units = 2'd1;
						end
					end
				end
			end
		end

		unit_sum = {1'b0, cur.units} + (LEN_W+1)'(add_units);
		st.units = unit_sum[LEN_W] ? UNIT_MAX : unit_sum[LEN_W-1:0];

		too_long = (st.byte_count > {1'b0, max_text_bytes}) || st.byte_count[LEN_W];

		result.utf16_units = '0;
		if (too_long) begin
			result.status = STATUS_TOO_LONG;
		end else if (st.nul_seen) begin
			result.status = STATUS_NUL;
		end else if (st.bad || st.pending != '0) begin
			// a truncated final sequence counts as bad encoding
			result.status = STATUS_BAD_UTF8;
		end else begin
			result.status      = STATUS_VALID;
			result.utf16_units = st.units;
		end

		nxt = end_of_text ? TEXT_STATE_CLEAR : st;
	end

endmodule

`default_nettype wire

// ----- design/utf8v_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module utf8v_out_buf
	import utf8v_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire result_t  push_data,
	output logic          can_push,
	utf8v_result_if.source result_out
);

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    out_free;

	assign out_free = !out_valid_q || result_out.ready;
	assign can_push = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: advance skid into output, or park the new beat in skid
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign result_out.valid       = out_valid_q;
	assign result_out.status      = out_data_q.status;
	assign result_out.utf16_units = out_data_q.utf16_units;

endmodule

`default_nettype wire

// ----- design/utf8_text_validator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir  Payload                                   Beat
// text_in      in   text_byte[7:0], has_byte, end_of_text     one byte of text
// result_out   out  status[1:0], utf16_units[15:0]            one result per text
// cfg          in   max_text_bytes[15:0]                      length limit write
//
// One byte beat per cycle while text_in is ready; the single decode step between
// the text state register and the result buffer sets that rate.
// A text's result is registered into the output register, or the skid while stalled.
// Reset clears the text state, empties the result buffer and sets the limit to 65535.
// A stalled result_out holds up to two results (output plus skid); text_in
// drops ready only while both are full. cfg is always ready.

module utf8_text_validator
	import utf8v_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	utf8v_byte_if.sink     text_in,
	utf8v_result_if.source result_out,
	utf8v_cfg_if.sink      cfg
);

	text_state_t      state_q;
	text_state_t      state_nxt;
	result_t          result;
	logic [LEN_W-1:0] max_bytes_q;
	logic             can_push;
	logic             accept;

	// Take a byte beat whenever the result buffer has room for one more text end.
	assign text_in.ready = can_push;
	assign accept        = text_in.valid && can_push;
	assign cfg.ready     = 1'b1;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= MAX_BYTES_RESET;
		end else if (cfg.valid) begin
			max_bytes_q <= cfg.max_text_bytes;
		end
	end

	// Decode one beat against the running text state.
	utf8v_step u_step (
		.cur            (state_q),
		.text_byte      (text_in.text_byte),
		.has_byte       (text_in.has_byte),
		.end_of_text    (text_in.end_of_text),
		.max_text_bytes (max_bytes_q),
		.nxt            (state_nxt),
		.result         (result)
	);

	// Advance the text state on each accepted beat; an end beat clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TEXT_STATE_CLEAR;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result register with skid stage toward the consumer.
	utf8v_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept && text_in.end_of_text),
		.push_data  (result),
		.can_push   (can_push),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

// ----- tb/tb_utf8_text_validator.sv -----
`timescale 1ns / 1ps

module tb_utf8_text_validator;
	import utf8v_pkg::*;

	logic clk;
	logic arst_n;

	utf8v_byte_if   text_in();
	utf8v_result_if result_out();
	utf8v_cfg_if    cfg();

	utf8_text_validator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	// Predicted decoder state, one copy of what the block keeps per text.
	logic [PEND_W-1:0]  pend_left;
	logic [SEQW_W-1:0]  seq_len;
	logic [CP_W-1:0]    code_acc;
	logic [LEN_W-1:0]   unit_total;
	logic [COUNT_W-1:0] byte_total;
	bit                 nul_hit;
	bit                 utf8_broken;
	logic [LEN_W-1:0]   length_limit;

	// Results still owed by the block, oldest first.
	result_t awaited_results[$];
	result_t got;

	int unsigned mismatches;
	int unsigned beats_accepted;
	int unsigned receiver_hold;
	bit          src_idle_on;
	bit          sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case a result never shows up or the input hangs.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_text_state();
		pend_left   = '0;
		seq_len     = SEQ_NONE;
		code_acc    = '0;
		unit_total  = '0;
		byte_total  = '0;
		nul_hit     = 1'b0;
		utf8_broken = 1'b0;
	endfunction

	// Add UTF-16 units, holding at the counter ceiling.
	function automatic void add_utf16_units(input int unsigned n);
		if (32'(unit_total) + n > 32'(UNIT_MAX))
			unit_total = UNIT_MAX;
		else
			unit_total = unit_total + LEN_W'(n);
	endfunction

	// Close a multi-byte sequence: reject overlong forms, surrogates and
	// values past the Unicode range, else count one or two units.
	function automatic void close_sequence();
		if ((seq_len == SEQ_TWO && code_acc < 21'h80) ||
			(seq_len == SEQ_THREE && code_acc < 21'h800) ||
			(seq_len == SEQ_FOUR && code_acc < 21'h10000) ||
			(code_acc >= 21'hd800 && code_acc <= 21'hdfff) ||
			code_acc > 21'h10ffff)
			utf8_broken = 1'b1;
		else
			add_utf16_units(code_acc > 21'hffff ? 2 : 1);
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		if (byte_total != BYTE_COUNT_MAX)
			byte_total++;
		if (b == 8'h00)
			nul_hit = 1'b1;
		// Once broken, bytes only count toward length and the NUL check.
		if (utf8_broken)
			return;
		if (pend_left == '0) begin
			if (b <= 8'h7f) begin
				add_utf16_units(1);
			end else if (b >= 8'hc2 && b <= 8'hdf) begin
				code_acc  = CP_W'(b[4:0]);
				seq_len   = SEQ_TWO;
				pend_left = 2'd1;
			end else if (b >= 8'he0 && b <= 8'hef) begin
				code_acc  = CP_W'(b[3:0]);
				seq_len   = SEQ_THREE;
				pend_left = 2'd2;
			end else if (b >= 8'hf0 && b <= 8'hf4) begin
				code_acc  = CP_W'(b[2:0]);
				seq_len   = SEQ_FOUR;
				pend_left = 2'd3;
			end else begin
				utf8_broken = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			utf8_broken = 1'b1;
		end else begin
			code_acc  = {code_acc[CP_W-7:0], b[5:0]};
			pend_left = pend_left - 2'd1;
			if (pend_left == '0)
				close_sequence();
		end
	endfunction

	// Apply one accepted beat; an end beat queues the verdict for the text.
	function automatic void track_text_beat(input logic [7:0] b, input bit has, input bit eot);
		result_t verdict;
		if (has)
			decode_byte(b);
		if (!eot)
			return;
		// A sequence still open at the end is a truncation.
		if (pend_left != '0)
			utf8_broken = 1'b1;
		verdict.utf16_units = '0;
		if (byte_total > COUNT_W'(length_limit) || byte_total > COUNT_W'(17'h0ffff))
			verdict.status = STATUS_TOO_LONG;
		else if (nul_hit)
			verdict.status = STATUS_NUL;
		else if (utf8_broken)
			verdict.status = STATUS_BAD_UTF8;
		else begin
			verdict.status      = STATUS_VALID;
			verdict.utf16_units = unit_total;
		end
		awaited_results.insert(awaited_results.size(), verdict);
		clear_text_state();
	endfunction

	// ------------------------------------------------------------------
	// Result side: receiver with random stalls and an on-demand long hold
	// ------------------------------------------------------------------

	initial begin
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (receiver_hold > 0) begin
				// Hold off long enough for the block to fill and stall text_in.
				result_out.ready <= 1'b0;
				while (receiver_hold > 0) begin
					@(posedge clk);
					receiver_hold--;
				end
				result_out.ready <= 1'b1;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				result_out.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				result_out.ready <= 1'b1;
			end else
				result_out.ready <= 1'b1;
		end
	end

	// Compare every result beat with the oldest owed verdict.
	always @(posedge clk) begin
		if (arst_n && result_out.valid && result_out.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d units=%0d",
					result_out.status, result_out.utf16_units));
			end else begin
				got = awaited_results.pop_front();
				if (result_out.status !== got.status)
					report_mismatch($sformatf("status %0d, want %s",
						result_out.status, got.status.name()));
				if (result_out.utf16_units !== got.utf16_units)
					report_mismatch($sformatf("utf16_units %0d, want %0d",
						result_out.utf16_units, got.utf16_units));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one beat and hold it until accepted; valid stays high afterward so
	// the next beat can follow back to back.
	task automatic send_beat(input logic [7:0] b, input bit has, input bit eot);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			text_in.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		text_in.valid       <= 1'b1;
		text_in.text_byte   <= b;
		text_in.has_byte    <= has;
		text_in.end_of_text <= eot;
		do @(posedge clk); while (!text_in.ready);
		track_text_beat(b, has, eot);
		if (has || eot)
			beats_accepted++;
	endtask

	// Send a whole text, the end marker on its last byte or on a bare beat.
	task automatic send_text(input logic [7:0] txt[$]);
		bit split_end;
		split_end = ($urandom_range(0, 4) == 0);
		if (txt.size() == 0) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			return;
		end
		foreach (txt[i]) begin
			// Sprinkle beats that carry neither byte nor end.
			if ($urandom_range(0, 19) == 0)
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_beat(txt[i], 1'b1, (i == txt.size() - 1) && !split_end);
		end
		if (split_end)
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// Drop valid, wait until every owed result has arrived, then let the
	// pipeline settle.
	task automatic drain_results();
		text_in.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] value);
		drain_results();
		cfg.max_text_bytes <= value;
		cfg.valid          <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		length_limit = value;
		cfg.valid <= 1'b0;
	endtask

	// Append cp as UTF-8 in the given width; a wider width gives an overlong form.
	function automatic void encode_utf8(input logic [CP_W-1:0] cp, input int width,
		ref logic [7:0] txt[$]);
		case (width)
			1: txt.insert(txt.size(), {1'b0, cp[6:0]});
			2: begin
				txt.insert(txt.size(), {3'b110, cp[10:6]});
				txt.insert(txt.size(), {2'b10, cp[5:0]});
			end
			3: begin
				txt.insert(txt.size(), {4'b1110, cp[15:12]});
				txt.insert(txt.size(), {2'b10, cp[11:6]});
				txt.insert(txt.size(), {2'b10, cp[5:0]});
			end
			default: begin
				txt.insert(txt.size(), {5'b11110, cp[20:18]});
				txt.insert(txt.size(), {2'b10, cp[17:12]});
				txt.insert(txt.size(), {2'b10, cp[11:6]});
				txt.insert(txt.size(), {2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int natural_width(input logic [CP_W-1:0] cp);
		if (cp < 21'h80)
			return 1;
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	function automatic logic [CP_W-1:0] pick_scalar();
		logic [CP_W-1:0] cp;
		case ($urandom_range(0, 9)) inside
			[0:3]: cp = CP_W'($urandom_range(1, 'h7f));
			[4:5]: cp = CP_W'($urandom_range('h80, 'h7ff));
			[6:7]: begin
				cp = CP_W'($urandom_range('h800, 'hffff));
				// Step out of the surrogate block.
				if (cp >= 21'hd800 && cp <= 21'hdfff)
					cp = cp ^ 21'h2000;
			end
			8: cp = CP_W'($urandom_range('h10000, 'h10ffff));
			default: begin
				case ($urandom_range(0, 8))
					0: cp = 21'h7f;
					1: cp = 21'h80;
					2: cp = 21'h7ff;
					3: cp = 21'h800;
					4: cp = 21'hd7ff;
					5: cp = 21'he000;
					6: cp = 21'hffff;
					7: cp = 21'h10000;
					default: cp = 21'h10ffff;
				endcase
			end
		endcase
		return cp;
	endfunction

	function automatic void push_clean_run(input int count, ref logic [7:0] txt[$]);
		logic [CP_W-1:0] cp;
		repeat (count) begin
			cp = pick_scalar();
			encode_utf8(cp, natural_width(cp), txt);
		end
	endfunction

	// Mostly well-formed texts; the rest carry one kind of damage, with
	// clean code points possibly following it.
	task automatic send_random_text();
		logic [7:0]      txt[$];
		logic [CP_W-1:0] cp;
		int              pos;
		txt = {};
		push_clean_run($urandom_range(0, 8), txt);
		if ($urandom_range(0, 99) >= 70) begin
			case ($urandom_range(0, 6))
				0: repeat ($urandom_range(1, 8))
					txt.insert(txt.size(), 8'($urandom_range(0, 255)));
				1: if (txt.size() > 0) void'(txt.pop_back());
				2: if (txt.size() > 0) begin
					pos = $urandom_range(0, txt.size() - 1);
					txt[pos] = 8'($urandom_range(0, 255));
				end
				3: begin
					// Overlong: encode a small value one or more widths too wide.
					cp = CP_W'($urandom_range(0, 'h7ff));
					encode_utf8(cp, $urandom_range(natural_width(cp) + 1, 4), txt);
				end
				4: encode_utf8(CP_W'($urandom_range('hd800, 'hdfff)), 3, txt);
				5: encode_utf8(CP_W'($urandom_range('h110000, 'h13ffff)), 4, txt);
				default: txt.insert($urandom_range(0, txt.size()), 8'h00);
			endcase
			push_clean_run($urandom_range(0, 3), txt);
		end
		send_text(txt);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		logic [7:0] txt[$];
		txt = {};
		send_text(txt);                                  // empty text
		send_beat(8'hff, 1'b0, 1'b0);                    // neither byte nor end
		txt = '{8'h7f};                         send_text(txt);
		txt = '{8'hc2, 8'h80};                  send_text(txt);
		txt = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};    send_text(txt); // top of range, 2 units
		txt = '{8'he0, 8'h9f, 8'hbf};           send_text(txt); // overlong 3-byte
		txt = '{8'hf0, 8'h8f, 8'hbf, 8'hbf};    send_text(txt); // overlong 4-byte
		txt = '{8'hed, 8'ha0, 8'h80};           send_text(txt); // surrogate
		txt = '{8'hf4, 8'h90, 8'h80, 8'h80};    send_text(txt); // past 10FFFF
		txt = '{8'he2, 8'h82};                  send_text(txt); // truncated at end
		txt = '{8'he2, 8'h00};                  send_text(txt); // NUL inside a sequence
	endtask

	task automatic test_limit_extremes();
		logic [7:0] txt[$];
		write_limit(16'h0000);
		txt = {};            send_text(txt);     // empty still fits
		txt = '{8'h41};      send_text(txt);
		write_limit(16'd2);
		txt = '{8'h00, 8'hff};        send_text(txt); // NUL outranks bad UTF-8
		txt = '{8'hff, 8'h41};        send_text(txt);
		txt = '{8'h00, 8'hff, 8'h41}; send_text(txt); // length outranks both
		write_limit(MAX_BYTES_RESET);
	endtask

	// Random texts in phases, each phase under its own length limit.
	task automatic test_random_texts(input int unsigned beat_target);
		while (beats_accepted < beat_target) begin
			case ($urandom_range(0, 3))
				0: write_limit(16'hffff);
				1: write_limit(LEN_W'($urandom_range(0, 40)));
				2: write_limit(LEN_W'($urandom_range(0, 65535)));
				default: write_limit(LEN_W'($urandom_range(8, 24)));
			endcase
			repeat ($urandom_range(10, 30))
				send_random_text();
		end
	endtask

	// Stall the receiver while texts keep coming, then pause the sender until
	// every result is back.
	task automatic test_backpressure();
		logic [7:0] txt[$];
		src_idle_on   = 1'b0;
		receiver_hold = 300;
		repeat (40) begin
			txt = '{8'($urandom_range(1, 127))};
			send_text(txt);
		end
		drain_results();
		src_idle_on = 1'b1;
	endtask

	// Texts at the length limit at full rate: exactly the limit fits, one more
	// byte does not.
	task automatic test_length_bound();
		int limit;
		limit = int'($urandom_range(16, 40));
		write_limit(LEN_W'(limit));
		for (int i = 0; i < limit; i++)
			send_beat(8'($urandom_range(1, 127)), 1'b1, i == limit - 1);
		for (int i = 0; i <= limit; i++)
			send_beat(8'($urandom_range(1, 127)), 1'b1, i == limit);
		write_limit(MAX_BYTES_RESET);
	endtask

	initial begin
		arst_n              <= 1'b0;
		text_in.valid       <= 1'b0;
		text_in.text_byte   <= '0;
		text_in.has_byte    <= 1'b0;
		text_in.end_of_text <= 1'b0;
		cfg.valid           <= 1'b0;
		cfg.max_text_bytes  <= '0;
		mismatches     = 0;
		beats_accepted = 0;
		receiver_hold  = 0;
		src_idle_on    = 1'b1;
		sink_idle_on   = 1'b1;
		length_limit   = MAX_BYTES_RESET;
		clear_text_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limit_extremes();
		test_random_texts(1350);
		test_backpressure();

		// Last part of the run: no idling on either side.
		drain_results();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		test_random_texts(1650);
		test_length_bound();

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- utf8_text_validator.f -----
design/utf8v_pkg.sv
design/utf8v_channels.sv
design/utf8v_step.sv
design/utf8v_out_buf.sv
design/utf8_text_validator.sv
tb/tb_utf8_text_validator.sv
